>>> rtl/core/uad_pkg.sv
// Package for the unsigned to ASCII digits core: sizes, queue entry types,
// front-end state encoding and the digit to character mapping.
// No dependencies.
`timescale 1ns / 1ps

package uad_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int DEC_DIGITS   = 10;  // decimal digits of a VALUE_BITS number
  localparam int BCD_W        = 4 * DEC_DIGITS;
  localparam int CONV_STEPS   = VALUE_BITS / 4;  // four bits per cycle
  localparam int CNT_W        = $clog2(CONV_STEPS);
  localparam int IDX_W        = $clog2(DEC_DIGITS);
  localparam int CHAR_W       = 7;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER = 7'h61;
  localparam logic [3:0]        DEC_RADIX   = 4'd10;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_UPPER_HEX = 1'b0;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_t;

  typedef struct packed {
    logic [BCD_W-1:0] digits;
    logic [IDX_W-1:0] top;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] res;
    if (d < DEC_RADIX) begin
      res = ASCII_ZERO + CHAR_W'(d);
    end else begin
      res = (upper ? ASCII_UPPER : ASCII_LOWER) + CHAR_W'(d - DEC_RADIX);
    end
    return res;
  endfunction

endpackage

>>> rtl/core/uad_in_if.sv
// Input channel of the unsigned to ASCII digits core.
// Depends on uad_pkg.
`timescale 1ns / 1ps

interface uad_in_if;
  import uad_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  radix_hex;

  modport source (output valid, value, radix_hex, input ready);
  modport sink   (input valid, value, radix_hex, output ready);
endinterface

>>> rtl/core/uad_out_if.sv
// Result channel of the unsigned to ASCII digits core, one character per transfer.
// Depends on uad_pkg.
`timescale 1ns / 1ps

interface uad_out_if;
  import uad_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, character, last_char, input ready);
  modport sink   (input valid, character, last_char, output ready);
endinterface

>>> rtl/core/unsigned_to_ascii_digits_core.sv
// Unsigned to ASCII digits core: front end, digit queue, emitter, config register.
// The front end converts to BCD four bits per cycle (shift-and-add-3) and takes
// a new number only once the digits of the previous one are pushed; the emitter
// sends one character per cycle while the output is ready.
// Reset: synchronous, active low; clears control state and upper_case_hex.
`timescale 1ns / 1ps

module unsigned_to_ascii_digits_core
  import uad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  uad_in_if.sink                in_ch,
  uad_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  q_push_t  push;
  logic     push_ready;
  logic     pop_valid;
  q_entry_t pop_entry;
  logic     pop_ready;
  q_stat_t  q_stat;
  logic     upper_r, upper_nxt;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign upper_nxt  = (cfg_wr && cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_UPPER_HEX) ?
                      cfg_pwdata[0] : upper_r;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == CFG_IDX_UPPER_HEX) ?
                      CFG_DATA_W'(upper_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= 1'b0;
    end else begin
      upper_r <= upper_nxt;
    end
  end

  uad_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  uad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready),
    .stat       (q_stat)
  );

  uad_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready),
    .upper_hex  (upper_r),
    .out_ch     (out_ch)
  );

  a_char_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.character >= 7'h30 && out_ch.character <= 7'h39) ||
                      (out_ch.character >= 7'h41 && out_ch.character <= 7'h46) ||
                      (out_ch.character >= 7'h61 && out_ch.character <= 7'h66)))
    else $error("character outside digit set");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("front end took a transfer while converting");

endmodule

>>> rtl/core/uad_front.sv
// Front end: accepts a number, converts it to BCD (shift-and-add-3, four bits
// per cycle) or splits it into nibbles for hex, and pushes the digits.
// Depends on uad_pkg and uad_in_if.
`timescale 1ns / 1ps

module uad_front
  import uad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  uad_in_if.sink      in_ch,
  output q_push_t     push,
  input  logic        push_ready
);

  fe_state_t             state_r, state_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      top;
  logic                  accept;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.radix_hex ? FE_PUSH : FE_CONV;
        end
      end
      FE_CONV: begin
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) begin
          state_nxt = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (push_ready) begin
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    case (state_r)
      FE_IDLE: in_ch.ready = 1'b1;
      default: ;
    endcase
  end

  assign push.valid = (state_r == FE_PUSH);

  // Datapath: load, then four double-dabble bit steps per cycle
  always_comb begin
    logic [BCD_W-1:0]      t;
    logic [VALUE_BITS-1:0] b;
    t       = bcd_r;
    b       = bin_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      bin_nxt = in_ch.value;
      cnt_nxt = '0;
      bcd_nxt = in_ch.radix_hex ? BCD_W'(in_ch.value) : '0;
    end else if (state_r == FE_CONV) begin
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
          if (t[i*4 +: 4] >= 4'd5) begin
            t[i*4 +: 4] = t[i*4 +: 4] + 4'd3;
          end
        end
        t = {t[BCD_W-2:0], b[VALUE_BITS-1]};
        b = {b[VALUE_BITS-2:0], 1'b0};
      end
      bcd_nxt = t;
      bin_nxt = b;
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // Most significant non-zero digit; zero gives digit 0
  always_comb begin
    top = '0;
    for (int i = 1; i < DEC_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        top = IDX_W'(i);
      end
    end
  end

  assign push.entry.digits = bcd_r;
  assign push.entry.top    = top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

>>> rtl/core/uad_queue.sv
// Two-entry queue of digit records between the front end and the emitter.
// Depends on uad_pkg.
`timescale 1ns / 1ps

module uad_queue
  import uad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  q_push_t  push,
  output logic     push_ready,
  output logic     pop_valid,
  output q_entry_t pop_entry,
  input  logic     pop_ready,
  output q_stat_t  stat
);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full   = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty  = (cnt_r == '0);
  assign push_ready  = !stat.full;
  assign pop_valid   = !stat.empty;
  assign pop_entry   = mem_r[rptr_r];
  assign do_push     = push.valid && push_ready;
  assign do_pop      = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push.entry;
    end
  end

endmodule

>>> rtl/core/uad_back.sv
// Emitter: walks a digit record from its top digit down and sends one ASCII
// character per transfer through an output register.
// Depends on uad_pkg and uad_out_if.
`timescale 1ns / 1ps

module uad_back
  import uad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  input  q_entry_t  pop_entry,
  output logic      pop_ready,
  input  logic      upper_hex,
  uad_out_if.source out_ch
);

  logic              busy_r, busy_nxt;
  logic [BCD_W-1:0]  digits_r, digits_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              advance;
  logic              done;

  assign advance   = busy_r && (!ovalid_r || out_ch.ready);
  assign done      = advance && (idx_r == '0);
  assign pop_ready = !busy_r || done;

  always_comb begin
    busy_nxt   = busy_r;
    digits_nxt = digits_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    if (advance) begin
      ovalid_nxt = 1'b1;
      char_nxt   = digit_char(digits_r[idx_r*4 +: 4], upper_hex);
      last_nxt   = (idx_r == '0);
      if (idx_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - IDX_W'(1);
      end
    end else if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
    if (pop_valid && pop_ready) begin
      busy_nxt   = 1'b1;
      digits_nxt = pop_entry.digits;
      idx_nxt    = pop_entry.top;
    end
  end

  assign out_ch.valid     = ovalid_r;
  assign out_ch.character = char_r;
  assign out_ch.last_char = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    idx_r    <= idx_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

endmodule

>>> bench/unsigned_to_ascii_digits_core_test.sv
// Testbench for unsigned_to_ascii_digits_core. It drives numbers and radix selects in,
// predicts the ASCII digit stream per number and checks every character transfer out.
// Depends on uad_pkg, uad_in_if, uad_out_if and the core itself.
`timescale 1ns / 1ps

module unsigned_to_ascii_digits_core_test;
  import uad_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } digit_char_t;

  class ascii_digit_checker;
    digit_char_t owed_chars[$];
    bit          upper_hex;
    int          errors;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_number(logic [VALUE_BITS-1:0] value, logic radix_hex);
      logic [VALUE_BITS-1:0] rest;
      logic [CHAR_W-1:0]     chars[$];
      logic [3:0]            d;
      int unsigned           radix;
      digit_char_t           item;
      rest  = value;
      radix = radix_hex ? 16 : 10;
      do begin
        d = 4'(rest % radix);
        if (d < 10) begin
          chars.push_front(ASCII_ZERO + CHAR_W'(d));
        end else begin
          chars.push_front((upper_hex ? ASCII_UPPER : ASCII_LOWER) + CHAR_W'(d - 10));
        end
        rest = rest / radix;
      end while (rest != 0);
      foreach (chars[k]) begin
        item.character = chars[k];
        item.last_char = (k == chars.size() - 1);
        owed_chars.push_back(item);
      end
    endfunction

    task check_char(logic [CHAR_W-1:0] character, logic last_char);
      digit_char_t want;
      if (owed_chars.size() == 0) begin
        report($sformatf("character 0x%02h with none outstanding", character));
        return;
      end
      want = owed_chars.pop_front();
      if (character !== want.character)
        report($sformatf("character 0x%02h, wanted 0x%02h", character, want.character));
      if (last_char !== want.last_char)
        report($sformatf("last_char %b, wanted %b", last_char, want.last_char));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int tx_idle_pct;
  int rx_idle_pct;

  ascii_digit_checker digits_sb;

  uad_in_if  in_ch();
  uad_out_if out_ch();

  unsigned_to_ascii_digits_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  localparam logic [CFG_ADDR_W-1:0] UPPER_HEX_ADDR = CFG_ADDR_W'(4 * CFG_IDX_UPPER_HEX);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      digits_sb.check_char(out_ch.character, out_ch.last_char);
  end

  task automatic send_number(input logic [VALUE_BITS-1:0] value, input logic radix_hex);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= value;
    in_ch.radix_hex <= radix_hex;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    digits_sb.note_number(value, radix_hex);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (digits_sb.owed_chars.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // setup cycle, then access cycle; pready is tied high so no access waits
  task automatic set_upper_hex(input bit upper);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= UPPER_HEX_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(upper);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    digits_sb.upper_hex = upper;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== CFG_DATA_W'(upper))
      digits_sb.report($sformatf("upper_case_hex read 0x%08h, wanted %0d", cfg_prdata, upper));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int count, input int tx_pct, input int rx_pct,
                                  input int drain_at);
    logic [VALUE_BITS-1:0] value;
    logic                  radix_hex;
    int unsigned           p;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      radix_hex = 1'($urandom_range(1, 0));
      case ($urandom_range(4, 0))
        0: value = $urandom;
        1: value = $urandom_range(20, 0);
        2: value = $urandom >> $urandom_range(31, 0);
        3: begin
          p = 1;
          repeat ($urandom_range(radix_hex ? 7 : 9, 1)) p = p * (radix_hex ? 16 : 10);
          value = p - $urandom_range(1, 0);
        end
        default: value = 32'hFFFF_FFFF - $urandom_range(3, 0);
      endcase
      send_number(value, radix_hex);
      if (n == drain_at) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [VALUE_BITS-1:0] directed_vals[10];
    digits_sb       = new();
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.radix_hex = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 30;
    directed_vals   = '{32'd0, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'd15, 32'd16,
                        32'd999_999_999, 32'd1_000_000_000, 32'hABCD_EF01, 32'h8000_0000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // letters a-f from reset, then A-F
    foreach (directed_vals[i]) send_number(directed_vals[i], i[0]);
    send_number(32'hFEDC_BA98, 1'b1);
    wait_drained();
    set_upper_hex(1'b1);
    foreach (directed_vals[i]) send_number(directed_vals[i], ~i[0]);
    send_number(32'hFEDC_BA98, 1'b1);
    wait_drained();

    set_upper_hex(1'b0);
    run_random_phase(110, 9, 54, 50);
    set_upper_hex(1'b1);
    run_random_phase(110, 54, 9, -1);
    set_upper_hex(1'($urandom_range(1, 0)));
    run_random_phase(110, 0, 0, -1);

    if (digits_sb.errors == 0 && digits_sb.owed_chars.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
